### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Operation and status codes, the stored entry layout and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_POP_HIGH = 2'd1,
    FUNC_POP_LOW  = 2'd2,
    FUNC_REMOVE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_READ,
    CMD_INS_SHIFT,
    CMD_INS_PLACE,
    CMD_REM_TAKE,
    CMD_REM_SHIFT,
    CMD_REM_SKIP,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    logic is_ins;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_end;
    logic hit;
    logic found;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### src/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if: request channel of the sorted priority queue
// Valid/ready channel carrying one queue operation per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic        valid;
  logic        ready;
  func_e       func;
  logic [15:0] proc_id;
  logic [7:0]  priority_req;

  modport source (output valid, output func, output proc_id, output priority_req,
                  input ready);
  modport sink   (input valid, input func, input proc_id, input priority_req,
                  output ready);
endinterface

`default_nettype wire

### src/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if: response channel of the sorted priority queue
// Valid/ready channel carrying one operation result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_rsp_if;
  import spq_pkg::*;

  logic        valid;
  logic        ready;
  status_e     status;
  logic [15:0] out_id;
  logic [7:0]  out_priority;
  logic [4:0]  occupancy;

  modport source (output valid, output status, output out_id, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_id, input out_priority,
                  input occupancy, output ready);
endinterface

`default_nettype wire

### src/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath: entry memory, scan index and result register
// Executes one controller command per cycle: reads one entry, moves one
// entry by one place, places a new entry or retires the result.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  spq_pkg::cmd_e       cmd_i,
  output spq_pkg::dp_status_t status_o,
  input  spq_pkg::func_e      func_i,
  input  wire [15:0]          proc_id_i,
  input  wire [7:0]           priority_req_i,
  spq_rsp_if.source           rsp_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  entry_t mem [CAPACITY];

  func_e       op_q;
  logic [15:0] id_q;
  logic [7:0]  pri_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic        found_q, found_d;
  logic [15:0] res_id_q, res_id_d;
  logic [7:0]  res_pri_q, res_pri_d;
  entry_t      rd_q;

  logic        out_valid_q, out_valid_d;
  status_e     out_status_q;
  logic [15:0] out_id_q;
  logic [7:0]  out_pri_q;
  logic [4:0]  out_occ_q;

  logic          is_ins;
  logic [CW-1:0] idx_m1;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [CW+4:0] occ_ext;

  assign is_ins = (op_q == FUNC_INSERT);
  assign idx_m1 = idx_q - ONE_C;

  always_comb begin
    status_o.is_ins   = is_ins;
    status_o.full     = (count_q == CAP_C);
    status_o.empty    = (count_q == '0);
    status_o.idx_zero = (idx_q == '0);
    status_o.idx_end  = (idx_q >= count_q);
    // insert stops at the first entry of equal or higher priority
    status_o.hit      = is_ins ? (rd_q.pri >= pri_q)
                               : ((op_q != FUNC_REMOVE) || (rd_q.id == id_q));
    status_o.found    = found_q;
    status_o.out_busy = out_valid_q && !rsp_o.ready;
  end

  // memory port control
  always_comb begin
    rd_en   = (cmd_i == CMD_READ);
    rd_addr = is_ins ? idx_m1[AW-1:0] : idx_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = rd_q;
    case (cmd_i)
      CMD_INS_SHIFT: wr_en = 1'b1;
      CMD_INS_PLACE: begin
        wr_en   = 1'b1;
        wr_data = '{id: id_q, pri: pri_q};
      end
      CMD_REM_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    res_id_d    = res_id_q;
    res_pri_d   = res_pri_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    unique case (cmd_i)
      CMD_LOAD: begin
        found_d   = 1'b0;
        res_id_d  = '0;
        res_pri_d = '0;
        case (func_i)
          FUNC_INSERT:  idx_d = count_q;
          FUNC_POP_LOW: idx_d = count_q - ONE_C;
          default:      idx_d = '0;
        endcase
      end
      CMD_INS_SHIFT: idx_d = idx_m1;
      CMD_INS_PLACE: begin
        found_d = 1'b1;
        count_d = count_q + ONE_C;
      end
      CMD_REM_TAKE: begin
        found_d   = 1'b1;
        res_id_d  = rd_q.id;
        res_pri_d = rd_q.pri;
        idx_d     = idx_q + ONE_C;
      end
      CMD_REM_SHIFT, CMD_REM_SKIP: idx_d = idx_q + ONE_C;
      CMD_FIN: begin
        out_valid_d = 1'b1;
        if (found_q && !is_ins) begin
          count_d = count_q - ONE_C;
        end
      end
      CMD_NONE, CMD_READ: ;
      default: ;
    endcase
  end

  assign occ_ext = {5'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    res_id_q  <= res_id_d;
    res_pri_q <= res_pri_d;
    if (cmd_i == CMD_LOAD) begin
      op_q  <= func_i;
      id_q  <= proc_id_i;
      pri_q <= priority_req_i;
    end
    if (cmd_i == CMD_FIN) begin
      out_status_q <= found_q ? ST_OK : (is_ins ? ST_FULL : ST_EMPTY);
      out_id_q     <= res_id_q;
      out_pri_q    <= res_pri_q;
      out_occ_q    <= occ_ext[4:0];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.out_id       = out_id_q;
  assign rsp_o.out_priority = out_pri_q;
  assign rsp_o.occupancy    = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count above capacity");

  a_place_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_INS_PLACE |-> count_q < CAP_C)
    else $error("insert placed into a full store");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_FIN) && found_q && !is_ins |-> count_q != '0)
    else $error("removal retired on an empty store");

endmodule

`default_nettype wire

### src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer of the sorted priority queue
// Walks the entry list one read and one move at a time and retires the
// result into the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  spq_pkg::dp_status_t status_i,
  output spq_pkg::cmd_e       cmd_o
);
  import spq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (status_i.is_ins) begin
          if (status_i.full) begin
            state_d = S_FIN;
          end else if (status_i.idx_zero) begin
            cmd_o   = CMD_INS_PLACE;
            state_d = S_FIN;
          end else begin
            cmd_o   = CMD_READ;
            state_d = S_EVAL;
          end
        end else if (status_i.empty || status_i.idx_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_READ;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_STEP;
        if (status_i.is_ins) begin
          if (status_i.hit) begin
            cmd_o   = CMD_INS_PLACE;
            state_d = S_FIN;
          end else begin
            cmd_o = CMD_INS_SHIFT;
          end
        end else if (status_i.found) begin
          // close the gap behind the removed entry
          cmd_o = CMD_REM_SHIFT;
        end else if (status_i.hit) begin
          cmd_o = CMD_REM_TAKE;
        end else begin
          cmd_o = CMD_REM_SKIP;
        end
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o   = CMD_FIN;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> $past(cmd_o == CMD_READ))
    else $error("entry evaluated without a read");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_STEP)
    else $error("accepted request did not start a walk");

  a_place_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o == CMD_INS_PLACE |-> status_i.is_ins && !status_i.full)
    else $error("place issued outside a legal insert");

endmodule

`default_nettype wire

### src/sorted_priority_queue_with_removal_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_removal_unit: sorted list priority queue
// Holds up to CAPACITY (id, priority) entries in descending priority order.
//
// Channels: req_i carries one operation per transfer (insert, pop highest,
// pop lowest, remove by id); rsp_o returns exactly one result per request
// with status, removed entry and occupancy. Both are valid/ready.
// Timing: one request is worked on at a time. The entry store is a single
// memory with one read and one write port, and every entry visited is read
// and then evaluated. Insert walks from the tail towards the head, moving
// each entry of lower priority down one place, and places the new entry
// behind the first of equal or higher priority or at the head; a removal
// walks from its first visited place to the end, takes the matching entry
// and moves each later entry up one place; a full insert or an empty pop
// visits no entry. A new request is taken while the previous result still
// waits in the output register; if the receiver stalls, the next result is
// held in the datapath until the register frees. Reset empties the queue
// and drops any pending result; the memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_with_removal_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  cmd_e       cmd;
  dp_status_t dp_status;
  logic       in_ready;

  assign req_i.ready = in_ready;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .func_i         (req_i.func),
    .proc_id_i      (req_i.proc_id),
    .priority_req_i (req_i.priority_req),
    .rsp_o          (rsp_o)
  );

endmodule

`default_nettype wire

### sim/sorted_priority_queue_with_removal_unit_checker.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_removal_unit_checker: result checker
// Watches the request and response channels, keeps its own sorted list of
// (id, priority) entries, predicts one result per accepted request and
// compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_removal_unit_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire clk_i,
  input  wire rst_ni,
  spq_req_if  req_i,
  spq_rsp_if  rsp_i,
  output int  errors_o,
  output int  pending_o
);
  import spq_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    status_e     status;
    logic [15:0] id;
    logic [7:0]  pri;
    logic [4:0]  occ;
  } queue_result_t;

  // sorted shadow store, head (highest priority) at index 0
  logic [15:0]   held_id  [CAPACITY];
  logic [7:0]    held_pri [CAPACITY];
  int unsigned   held;
  queue_result_t expected_results [$];
  int            mismatches;

  initial begin
    held = 0;
    mismatches = 0;
    pending_o = 0;
  end

  assign errors_o = mismatches;

  // Remove the entry at pos and close the gap.
  function automatic queue_result_t take_entry(int unsigned pos);
    queue_result_t r;
    int unsigned   k;
    r = '0;
    r.status = ST_OK;
    r.id = held_id[pos];
    r.pri = held_pri[pos];
    for (k = pos; k + 1 < held; k++) begin
      held_id[k] = held_id[k + 1];
      held_pri[k] = held_pri[k + 1];
    end
    held--;
    return r;
  endfunction

  function automatic queue_result_t apply_queue_op(func_e f, logic [15:0] id,
                                                   logic [7:0] p);
    queue_result_t r;
    int unsigned   pos;
    int unsigned   k;
    bit            hit;
    r = '0;
    r.status = ST_OK;
    case (f)
      FUNC_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // land behind every entry of equal or higher priority
          pos = 0;
          while (pos < held && held_pri[pos] >= p) pos++;
          for (k = held; k > pos; k--) begin
            held_id[k] = held_id[k - 1];
            held_pri[k] = held_pri[k - 1];
          end
          held_id[pos] = id;
          held_pri[pos] = p;
          held++;
        end
      end
      FUNC_POP_HIGH: begin
        if (held == 0) r.status = ST_EMPTY;
        else r = take_entry(0);
      end
      FUNC_POP_LOW: begin
        if (held == 0) r.status = ST_EMPTY;
        else r = take_entry(held - 1);
      end
      default: begin
        hit = 1'b0;
        for (k = 0; k < held && !hit; k++) begin
          if (held_id[k] == id) begin
            r = take_entry(k);
            hit = 1'b1;
          end
        end
        if (!hit) r.status = ST_EMPTY;
      end
    endcase
    r.occ = held[4:0];
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    queue_result_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected result status %0d id %h pri %h occ %0d", $realtime,
                     rsp_i.status, rsp_i.out_id, rsp_i.out_priority, rsp_i.occupancy);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_i.status !== want.status || rsp_i.out_id !== want.id ||
              rsp_i.out_priority !== want.pri || rsp_i.occupancy !== want.occ) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: mismatch exp st %0d id %h pri %h occ %0d, got st %0d id %h pri %h occ %0d",
                       $realtime, want.status, want.id, want.pri, want.occ, rsp_i.status,
                       rsp_i.out_id, rsp_i.out_priority, rsp_i.occupancy);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_results.push_back(apply_queue_op(req_i.func, req_i.proc_id,
                                                  req_i.priority_req));
      pending_o = expected_results.size();
    end
  end

endmodule

### sim/sorted_priority_queue_with_removal_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_removal_unit_tb: testbench top
// Drives directed and random queue operations with random gaps and
// receiver stalls, including one long hold-off that backs the queue up,
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_removal_unit_tb;
  import spq_pkg::*;

  localparam int unsigned CAPACITY        = 16;
  localparam int          TOTAL_ITEMS     = 1450;
  localparam int          CALM_ITEMS      = 150;
  localparam int          HOLD_OFF_AT     = 400;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          DRAIN_CYCLES    = 80;
  localparam int          CYCLE_LIMIT     = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   errors;
  int   pending;
  int   sent_cnt = 0;
  int   cycle_cnt = 0;
  bit   calm = 1'b0;
  bit   held_off = 1'b0;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue_with_removal_unit #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sorted_priority_queue_with_removal_unit_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one operation and hold it until the transfer.
  task automatic send_op(func_e f, logic [15:0] id, logic [7:0] p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= f;
    req_if.proc_id <= id;
    req_if.priority_req <= p;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Small id pool so removals hit and ids repeat; small priorities force ties.
  task automatic random_op(int unsigned insert_pct);
    func_e       f;
    logic [15:0] id;
    logic [7:0]  p;
    if ($urandom_range(0, 99) < insert_pct) f = FUNC_INSERT;
    else f = func_e'(2'($urandom_range(1, 3)));
    id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
    p = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_op(f, id, p);
  endtask

  // receiver: random stalls, one long hold-off, none near the end
  initial begin
    rsp_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!held_off && sent_cnt >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int          seg_left;
    int unsigned insert_pct;
    int          i;
    seg_left = 0;
    insert_pct = 50;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.func <= FUNC_INSERT;
    req_if.proc_id <= '0;
    req_if.priority_req <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty store: pops and a removal find nothing
    send_op(FUNC_POP_HIGH, 16'h0000, 8'h00);
    send_op(FUNC_POP_LOW, 16'hFFFF, 8'hFF);
    send_op(FUNC_REMOVE, 16'h1234, 8'h00);
    // extremes and priority ties at head, middle and tail
    send_op(FUNC_INSERT, 16'hFFFF, 8'hFF);
    send_op(FUNC_INSERT, 16'h0000, 8'h00);
    send_op(FUNC_INSERT, 16'h0010, 8'd100);
    send_op(FUNC_INSERT, 16'h0011, 8'd100);
    send_op(FUNC_INSERT, 16'h0012, 8'd100);
    send_op(FUNC_INSERT, 16'h0020, 8'hFF);
    send_op(FUNC_INSERT, 16'h0030, 8'h00);
    // fill up; the last insert lands on a full store
    for (i = 0; i < 10; i++)
      send_op(FUNC_INSERT, 16'h0100 + 16'(i), 8'(50 + 10 * i));
    send_op(FUNC_REMOVE, 16'h0011, 8'h00);
    send_op(FUNC_REMOVE, 16'hBEEF, 8'h00);
    send_op(FUNC_POP_HIGH, 16'h0000, 8'h00);
    send_op(FUNC_POP_LOW, 16'h0000, 8'h00);
    send_op(FUNC_REMOVE, 16'h0000, 8'h00);

    // segments with insert-heavy, balanced and drain-heavy mixes
    while (sent_cnt < TOTAL_ITEMS) begin
      calm = (sent_cnt >= TOTAL_ITEMS - CALM_ITEMS);
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      seg_left--;
      random_op(insert_pct);
    end
    req_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
